[design/hwsr_pkg.sv]
// Shared types and codes for the histogram with sorted readout.
package hwsr_pkg;

    // Item kinds
    localparam logic [1:0] KIND_OCCUR  = 2'd0;
    localparam logic [1:0] KIND_UNSORT = 2'd1;
    localparam logic [1:0] KIND_SORT   = 2'd2;
    localparam logic [1:0] KIND_IGNORE = 2'd3;

    // Register index of bins_in_use
    localparam logic REG_BINS_IN_USE = 1'b0;

    // Default number of active bins
    localparam logic [6:0] BINS_RESET = 7'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OCC,
        ST_URD,
        ST_UOUT,
        ST_SCAN,
        ST_SDRAIN,
        ST_SOUT
    } t_state;

endpackage

[design/hwsr_if.sv]
// Valid/ready channel interfaces for input items and result beats.
interface hwsr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] bin_id;

    modport source (output valid, output kind, output bin_id, input ready);
    modport sink (input valid, input kind, input bin_id, output ready);
endinterface

interface hwsr_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  out_bin;
    logic [31:0] out_count;
    logic        last;
    logic        error;

    modport source (output valid, output out_bin, output out_count, output last,
                    output error, input ready);
    modport sink (input valid, input out_bin, input out_count, input last,
                  input error, output ready);
endinterface

[design/hwsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hwsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/histogram_with_sorted_readout.sv]
// Histogram with sorted readout: top level.
//
// Input channel i_in carries beats of (kind, bin_id). An occurrence beat bumps
// the named bin counter (saturating) and yields no result, or one error beat
// (bin 0, count 0, last, error) if the id is not below the active bin count.
// A read-unsorted beat yields one (id, count) beat per active bin in id order;
// a read-sorted beat yields them by descending count, higher id first on ties.
// The final beat of a readout carries last. Kind three is dropped.
// Counters sit in one RAM with a registered read; each entry has a valid bit
// cleared at reset, so an unwritten bin reads as zero and no clearing pass runs.
// An occurrence reads the counter, then writes it back. An error beat is valid
// in the cycle after its item is accepted. An unsorted readout reads each bin,
// then emits its beat. A sorted readout rescans all N active bins for each
// beat it emits.
// Results leave through an output register. A new item is accepted only while
// the block is idle and that register is empty or its beat leaves in the same
// cycle. When the receiver stalls, the block holds the beat and pauses.
// Reset clears all counters and sets bins_in_use to 16.
// The user writes bins_in_use over APB only while the block is idle; the block does not enforce this.
module histogram_with_sorted_readout #(
    parameter int NUM_BINS   = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hwsr_in_if.sink     i_in,
    hwsr_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = NUM_BINS > 1 ? $clog2(NUM_BINS) : 1;
    localparam logic [6:0] NB = 7'(NUM_BINS);

    hwsr_pkg::t_state r_state, n_state;

    logic [6:0]            r_biu;
    logic [6:0]            nbins;
    logic [NUM_BINS-1:0]   r_valid;
    logic                  r_rv;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_rid;
    logic                  r_cv;
    logic [IW-1:0]         r_oid;
    logic [6:0]            r_pos;
    logic                  r_first;
    logic [COUNT_BITS-1:0] r_pcnt;
    logic [IW-1:0]         r_pid;
    logic                  r_hb;
    logic [COUNT_BITS-1:0] r_bcnt;
    logic [IW-1:0]         r_bid;

    logic                  r_ov;
    logic [5:0]            r_obin;
    logic [31:0]           r_ocnt;
    logic                  r_olast;
    logic                  r_oerr;

    logic                  mem_we, mem_re;
    logic [IW-1:0]         mem_waddr, mem_raddr;
    logic [COUNT_BITS-1:0] mem_wdata, mem_rdata, rd_cnt;
    logic                  out_free, accept, bad_id, idx_last, pos_last;
    logic                  cand_below, cand_better;

    // Active bin count, clamped to the bank size
    assign nbins = (r_biu > NB) ? NB : r_biu;

    // APB register access
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == hwsr_pkg::REG_BINS_IN_USE) begin
            prdata = {25'd0, r_biu};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= hwsr_pkg::BINS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == hwsr_pkg::REG_BINS_IN_USE) begin
            r_biu <= pwdata[6:0];
        end
    end

    hwsr_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Unwritten entries read as zero
    assign rd_cnt = r_rv ? mem_rdata : '0;

    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == hwsr_pkg::ST_IDLE) && out_free;
    assign accept = i_in.valid && i_in.ready;
    assign bad_id = i_in.bin_id >= {1'b0, nbins};
    assign idx_last = {{(7-IW){1'b0}}, r_idx} == nbins - 7'd1;
    assign pos_last = r_pos == nbins - 7'd1;

    // Sorted scan: candidate must rank below the previous beat and above the best so far
    assign cand_below = r_first || (rd_cnt < r_pcnt) || (rd_cnt == r_pcnt && r_rid < r_pid);
    assign cand_better = !r_hb || (rd_cnt > r_bcnt) || (rd_cnt == r_bcnt && r_rid > r_bid);

    // Next state and memory control
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_oid;
        mem_wdata = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        case (r_state)
            hwsr_pkg::ST_IDLE: begin
                mem_raddr = i_in.bin_id[IW-1:0];
                if (accept) begin
                    case (i_in.kind)
                        hwsr_pkg::KIND_OCCUR: begin
                            if (!bad_id) begin
                                mem_re  = 1'b1;
                                n_state = hwsr_pkg::ST_OCC;
                            end
                        end
                        hwsr_pkg::KIND_UNSORT: begin
                            if (nbins != 7'd0) n_state = hwsr_pkg::ST_URD;
                        end
                        hwsr_pkg::KIND_SORT: begin
                            if (nbins != 7'd0) n_state = hwsr_pkg::ST_SCAN;
                        end
                        default: n_state = hwsr_pkg::ST_IDLE;
                    endcase
                end
            end
            hwsr_pkg::ST_OCC: begin
                mem_we  = 1'b1;
                n_state = hwsr_pkg::ST_IDLE;
            end
            hwsr_pkg::ST_URD: begin
                mem_re  = 1'b1;
                n_state = hwsr_pkg::ST_UOUT;
            end
            hwsr_pkg::ST_UOUT: begin
                if (out_free) begin
                    n_state = pos_last ? hwsr_pkg::ST_IDLE : hwsr_pkg::ST_URD;
                end
            end
            hwsr_pkg::ST_SCAN: begin
                mem_re = 1'b1;
                if (idx_last) n_state = hwsr_pkg::ST_SDRAIN;
            end
            hwsr_pkg::ST_SDRAIN: begin
                n_state = hwsr_pkg::ST_SOUT;
            end
            hwsr_pkg::ST_SOUT: begin
                if (out_free) begin
                    n_state = pos_last ? hwsr_pkg::ST_IDLE : hwsr_pkg::ST_SCAN;
                end
            end
            default: n_state = hwsr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hwsr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Entry valid bits and read-side valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rv    <= 1'b0;
        end else begin
            if (mem_we) r_valid[mem_waddr] <= 1'b1;
            if (mem_re) r_rv <= r_valid[mem_raddr];
        end
    end

    // Readout control and scan tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv  <= 1'b0;
            r_hb  <= 1'b0;
        end else begin
            r_cv <= (r_state == hwsr_pkg::ST_SCAN);
            if (r_state == hwsr_pkg::ST_SOUT || r_state == hwsr_pkg::ST_IDLE) begin
                r_hb <= 1'b0;
            end else if (r_cv && cand_below && cand_better) begin
                r_hb <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rid <= r_idx;
        if (r_cv && cand_below && cand_better) begin
            r_bcnt <= rd_cnt;
            r_bid  <= r_rid;
        end
        case (r_state)
            hwsr_pkg::ST_IDLE: begin
                r_oid    <= i_in.bin_id[IW-1:0];
                r_idx    <= '0;
                r_pos    <= '0;
                r_first  <= 1'b1;
            end
            hwsr_pkg::ST_URD: begin
                r_oid <= r_idx;
            end
            hwsr_pkg::ST_UOUT: begin
                if (out_free) begin
                    r_idx <= r_idx + 1'b1;
                    r_pos <= r_pos + 7'd1;
                end
            end
            hwsr_pkg::ST_SCAN: begin
                r_idx <= idx_last ? '0 : r_idx + 1'b1;
            end
            hwsr_pkg::ST_SOUT: begin
                if (out_free) begin
                    r_pos   <= r_pos + 7'd1;
                    r_first <= 1'b0;
                    r_pcnt  <= r_bcnt;
                    r_pid   <= r_bid;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= (accept && i_in.kind == hwsr_pkg::KIND_OCCUR && bad_id)
                    || r_state == hwsr_pkg::ST_UOUT || r_state == hwsr_pkg::ST_SOUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_state == hwsr_pkg::ST_UOUT) begin
                r_obin  <= 6'(r_oid);
                r_ocnt  <= 32'(rd_cnt);
                r_olast <= pos_last;
                r_oerr  <= 1'b0;
            end else if (r_state == hwsr_pkg::ST_SOUT) begin
                r_obin  <= 6'(r_bid);
                r_ocnt  <= 32'(r_bcnt);
                r_olast <= pos_last;
                r_oerr  <= 1'b0;
            end else if (accept) begin
                r_obin  <= '0;
                r_ocnt  <= '0;
                r_olast <= 1'b1;
                r_oerr  <= 1'b1;
            end
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_bin   = r_obin;
    assign o_out.out_count = r_ocnt;
    assign o_out.last      = r_olast;
    assign o_out.error     = r_oerr;
endmodule

[verif/tb_histogram_with_sorted_readout.sv]
// Testbench for the histogram with sorted readout: random and directed items, scoreboard check.
`timescale 1ns / 1ps
module tb_histogram_with_sorted_readout;

    localparam int NBINS = 16;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] bin_id;
    } t_item;

    typedef struct packed {
        logic [5:0]  out_bin;
        logic [31:0] out_count;
        logic        last;
        logic        error;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    hwsr_in_if  in_ch ();
    hwsr_out_if out_ch ();

    histogram_with_sorted_readout i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state
    logic [31:0] hist_counts [NBINS];
    logic [6:0]  hist_bins;
    t_item pending_items [$];
    t_beat expected_beats [$];
    int n_errors = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    int quiet_cycles = 0;

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        n_errors++;
    endtask

    // Expected beats for one accepted item
    task automatic predict_histogram(input t_item it);
        int n;
        int order [NBINS];
        int cur, j;
        n = (hist_bins > NBINS) ? NBINS : hist_bins;
        if (it.kind == hwsr_pkg::KIND_OCCUR) begin
            if (it.bin_id >= n) begin
                expected_beats.insert(expected_beats.size(), '{6'd0, 32'd0, 1'b1, 1'b1});
            end else if (hist_counts[it.bin_id] != 32'hFFFF_FFFF) begin
                hist_counts[it.bin_id]++;
            end
            return;
        end
        if (it.kind == hwsr_pkg::KIND_IGNORE || n == 0) return;
        for (int i = 0; i < n; i++) order[i] = i;
        if (it.kind == hwsr_pkg::KIND_SORT) begin
            for (int i = 1; i < n; i++) begin
                cur = order[i];
                j = i;
                while (j > 0 && (hist_counts[cur] > hist_counts[order[j-1]] ||
                       (hist_counts[cur] == hist_counts[order[j-1]] && cur > order[j-1]))) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = cur;
            end
        end
        for (int i = 0; i < n; i++)
            expected_beats.insert(expected_beats.size(),
                                  '{order[i][5:0], hist_counts[order[i]], (i == n - 1), 1'b0});
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.kind <= '0;
            in_ch.bin_id <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                predict_histogram('{in_ch.kind, in_ch.bin_id});
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_item it;
                    it = pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.kind <= it.kind;
                    in_ch.bin_id <= it.bin_id;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_beats.size() == 0) begin
                    report($sformatf("unexpected beat bin=%0d", out_ch.out_bin));
                end else begin
                    t_beat e;
                    e = expected_beats.pop_front();
                    if (out_ch.out_bin !== e.out_bin)
                        report($sformatf("bin %0d exp %0d", out_ch.out_bin, e.out_bin));
                    if (out_ch.out_count !== e.out_count)
                        report($sformatf("count %0d exp %0d (bin %0d)",
                                         out_ch.out_count, e.out_count, e.out_bin));
                    if (out_ch.last !== e.last)
                        report($sformatf("last %0b exp %0b", out_ch.last, e.last));
                    if (out_ch.error !== e.error)
                        report($sformatf("error %0b exp %0b", out_ch.error, e.error));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic apb_write(input logic [6:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(hwsr_pkg::REG_BINS_IN_USE) * 3'd4; pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        hist_bins = value;
    endtask

    // Wait until the block is idle: all items sent, all beats in
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic push(input logic [1:0] k, input logic [7:0] id);
        pending_items.insert(pending_items.size(), '{k, id});
    endtask

    // Random phase: mostly occurrences with ids up to bins_in_use plus one, some readouts and noise
    task automatic random_items(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 70) push(hwsr_pkg::KIND_OCCUR, 8'($urandom_range(hist_bins + 1)));
            else if (r < 78) push(hwsr_pkg::KIND_OCCUR, 8'($urandom_range(255)));
            else if (r < 86) push(hwsr_pkg::KIND_UNSORT, 8'($urandom));
            else if (r < 95) push(hwsr_pkg::KIND_SORT, 8'($urandom));
            else push(hwsr_pkg::KIND_IGNORE, 8'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < NBINS; i++) hist_counts[i] = '0;
        hist_bins = hwsr_pkg::BINS_RESET;
        in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.bin_id = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 7; recv_idle_pct = 69;

        // Directed: extremes, every kind, error, ignored kind, ties
        push(hwsr_pkg::KIND_SORT, 8'h00);
        push(hwsr_pkg::KIND_OCCUR, 8'd0); push(hwsr_pkg::KIND_OCCUR, 8'd15);
        push(hwsr_pkg::KIND_OCCUR, 8'd15);
        push(hwsr_pkg::KIND_OCCUR, 8'd16); push(hwsr_pkg::KIND_OCCUR, 8'd255);
        push(hwsr_pkg::KIND_OCCUR, 8'd7);
        push(hwsr_pkg::KIND_IGNORE, 8'hAA); push(hwsr_pkg::KIND_IGNORE, 8'h55);
        push(hwsr_pkg::KIND_UNSORT, 8'hFF); push(hwsr_pkg::KIND_SORT, 8'h00);
        drain();

        // Smallest and largest settings, and above the bank size
        apb_write(7'd1);
        push(hwsr_pkg::KIND_OCCUR, 8'd0); push(hwsr_pkg::KIND_OCCUR, 8'd1);
        push(hwsr_pkg::KIND_UNSORT, 8'd0);
        push(hwsr_pkg::KIND_SORT, 8'd0);
        drain();
        apb_write(7'd0);
        push(hwsr_pkg::KIND_OCCUR, 8'd0); push(hwsr_pkg::KIND_UNSORT, 8'd0);
        push(hwsr_pkg::KIND_SORT, 8'd0);
        drain();
        apb_write(7'd127);
        push(hwsr_pkg::KIND_OCCUR, 8'd15); push(hwsr_pkg::KIND_OCCUR, 8'd16);
        push(hwsr_pkg::KIND_SORT, 8'd0);
        drain();
        apb_write(7'd64);
        random_items(50);
        drain();

        send_idle_pct = 69; recv_idle_pct = 7;
        apb_write(7'd5);
        random_items(40);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        apb_write(7'd16);
        random_items(60);
        drain();

        if (n_errors == 0 && expected_beats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
